// File: rtl/bba_pkg.sv
// Package with the constants, codes and types of the bitmap block allocator.
`default_nettype none
package bba_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int ADDR_SPAN  = 1024;
  localparam int MAP_BLOCKS = (NUM_BLOCKS < ADDR_SPAN) ? NUM_BLOCKS : ADDR_SPAN;
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = 5;
  localparam int NUM_WORDS  = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BLK_W      = 10;
  localparam int CNT_W      = 11;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int LANE_BITS  = 8;

  localparam logic [CNT_W-1:0]   MAP_LIMIT = CNT_W'(MAP_BLOCKS);
  localparam logic [CNT_W-1:0]   CFG_RESET = CNT_W'(1024);
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [BIT_W-1:0]     bit_idx;
    logic [1:0]           lane;
    logic [LANE_BITS-1:0] byte_bits;
    logic [LANE_BITS-1:0] lane_mask;
  } upd_req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 found;
    logic [BIT_W-1:0]     first;
    logic [3:0]           add;
    logic [3:0]           sub;
  } upd_res_t;

endpackage
`default_nettype wire

// File: rtl/bitmap_block_allocator.sv
// Top level of the first-fit free-block bitmap allocator.
// The bitmap lives in a memory of 32-bit words with registered reads. A free
// or a load reads, modifies and writes back one word; an allocate reads words
// from word zero, one word per cycle, and writes back the first word with a
// free bit; one item is taken at a time. Free and load pass through the access
// and pending states, an allocate through the scan and pending states, and an
// allocate with a zero free count, a free or load out of range, or a nop goes
// straight to the pending state. From there the result enters the output
// register as the block returns to idle; a stalled output keeps it pending.
// Writing blocks_in_use clears the whole bitmap and the free count; reset
// does the same and sets blocks_in_use to 1024.
`default_nettype none
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [CNT_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [OP_W-1:0]  opcode,
  input  wire logic [BLK_W-1:0] block_number,
  input  wire logic [7:0]       byte_bits,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [BLK_W-1:0] allocated_block,
  output logic      [CNT_W-1:0] free_count,
  output logic      [ST_W-1:0]  status
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ACCESS = 4'b0010,
    S_SCAN   = 4'b0100,
    S_PEND   = 4'b1000
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     blocks_in_use;
  logic [CNT_W-1:0]     free_total;
  logic [CNT_W-1:0]     limit;
  upd_req_t             req;
  upd_res_t             res;
  logic [WORD_AW-1:0]   word_idx;
  logic [BLK_W-1:0]     pend_block;
  logic [ST_W-1:0]      pend_status;
  logic                 rd_en;
  logic [WORD_AW-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [LANE_BITS-1:0] lane_mask;
  logic [CNT_W-1:0]     load_base;
  logic                 accept;
  logic                 commit;

  assign limit     = (blocks_in_use > MAP_LIMIT) ? MAP_LIMIT : blocks_in_use;
  assign load_base = {1'b0, block_number[BLK_W-1:3], 3'd0};
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign commit    = (state == S_PEND) && (!out_valid || out_ready);

  always_comb begin
    for (int i = 0; i < LANE_BITS; i++) begin
      lane_mask[i] = (load_base + CNT_W'(i)) < limit;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = block_number[BIT_W +: WORD_AW];
    if (accept) begin
      unique case (opcode)
        OP_ALLOC: begin
          rd_en   = (free_total != '0);
          rd_addr = '0;
        end
        OP_FREE:  rd_en = ({1'b0, block_number} < limit);
        OP_LOAD:  rd_en = (load_base < limit);
        default:  rd_en = 1'b0;
      endcase
    end else if ((state == S_SCAN) && !res.found && (word_idx != LAST_WORD)) begin
      rd_en   = 1'b1;
      rd_addr = word_idx + WORD_AW'(1);
    end
  end

  assign wr_en = (state == S_ACCESS) || ((state == S_SCAN) && res.found);

  bba_map_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_write),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (word_idx),
    .wr_data (res.word)
  );

  bba_word_logic u_logic (
    .word_in (rd_data),
    .req     (req),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req.op        <= opcode;
      req.bit_idx   <= block_number[BIT_W-1:0];
      req.lane      <= block_number[4:3];
      req.byte_bits <= byte_bits;
      req.lane_mask <= lane_mask;
    end
    if (rd_en) begin
      word_idx <= rd_addr;
    end
    if (commit) begin
      allocated_block <= pend_block;
      free_count      <= free_total;
      status          <= pend_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      blocks_in_use <= CFG_RESET;
      free_total    <= '0;
      out_valid     <= 1'b0;
      pend_block    <= '0;
      pend_status   <= ST_OK;
    end else begin
      if (cfg_write) begin
        blocks_in_use <= cfg_data;
        free_total    <= '0;
      end else if (wr_en) begin
        free_total <= free_total + CNT_W'(res.add) - CNT_W'(res.sub);
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend_block  <= '0;
            pend_status <= ST_OK;
            if (rd_en) begin
              state <= (opcode == OP_ALLOC) ? S_SCAN : S_ACCESS;
            end else begin
              state <= S_PEND;
              if (opcode == OP_ALLOC) begin
                pend_status <= ST_FULL;
              end else if (opcode != OP_NOP) begin
                pend_status <= ST_RANGE;
              end
            end
          end
        end
        S_ACCESS: begin
          state <= S_PEND;
        end
        S_SCAN: begin
          if (res.found) begin
            pend_block <= BLK_W'({word_idx, res.first});
            state      <= S_PEND;
          end else if (word_idx == LAST_WORD) begin
            pend_status <= ST_FULL;
            state       <= S_PEND;
          end
        end
        S_PEND: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/bba_map_mem.sv
// Bitmap word memory with one valid bit per word so that a clear only resets the valid bits.
`default_nettype none
module bba_map_mem
  import bba_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 clear,
  input  wire logic                 rd_en,
  input  wire logic [WORD_AW-1:0]   rd_addr,
  output logic      [WORD_BITS-1:0] rd_data,
  input  wire logic                 wr_en,
  input  wire logic [WORD_AW-1:0]   wr_addr,
  input  wire logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_valid;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule
`default_nettype wire

// File: rtl/bba_word_logic.sv
// Word modify logic: first free bit search, free, byte load and free count change.
`default_nettype none
module bba_word_logic
  import bba_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] word_in,
  input  wire upd_req_t             req,
  output upd_res_t                  res
);

  always_comb begin
    logic [BIT_W-1:0] pos;
    pos       = '0;
    res       = '0;
    res.word  = word_in;
    res.found = |word_in;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word_in[i]) begin
        res.first = BIT_W'(i);
      end
    end
    unique case (req.op)
      OP_ALLOC: begin
        if (res.found) begin
          res.word[res.first] = 1'b0;
          res.sub             = 4'd1;
        end
      end
      OP_FREE: begin
        res.word[req.bit_idx] = 1'b1;
        res.add               = {3'd0, ~word_in[req.bit_idx]};
      end
      OP_LOAD: begin
        for (int i = 0; i < LANE_BITS; i++) begin
          pos = {req.lane, 3'(i)};
          if (req.lane_mask[i]) begin
            res.word[pos] = req.byte_bits[i];
            res.sub       = res.sub + {3'd0, word_in[pos]};
            res.add       = res.add + {3'd0, req.byte_bits[i]};
          end
        end
      end
      default: begin
        res.word = word_in;
      end
    endcase
  end

endmodule
`default_nettype wire
